### rtl/core/gnb_pkg.sv
// ----------------------------------------------------------------------------
// gnb_pkg
// shared types and constants of the gaussian naive bayes classifier core
// ----------------------------------------------------------------------------
package gnb_pkg;

  localparam logic [1:0] CMD_LOAD_MEAN  = 2'd0;
  localparam logic [1:0] CMD_LOAD_DEV   = 2'd1;
  localparam logic [1:0] CMD_LOAD_PRIOR = 2'd2;
  localparam logic [1:0] CMD_SAMPLE     = 2'd3;

  localparam logic CFG_CLASSES_IN_USE = 1'b0;
  localparam logic CFG_DEFAULT_CLASS  = 1'b1;

  localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};
  localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};

  typedef struct packed {
    logic [1:0]         cmd;
    logic [3:0]         class_index;
    logic [5:0]         attr_index;
    logic signed [31:0] value;
    logic               present;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [3:0]         winner;
    logic signed [47:0] best_score;
    logic               used_default;
  } result_t;

  // control travelling with each class through the divider row
  typedef struct packed {
    logic vld;
    logic sat;
  } flag_t;

endpackage

### rtl/core/gaussian_naive_bayes_classify_core.sv
// ----------------------------------------------------------------------------
// gaussian_naive_bayes_classify_core
// gaussian naive bayes classifier, q16.16 tables, one attribute per sample
// ----------------------------------------------------------------------------
//  channel   ports                              transfer when
//  item      start_i, busy_o, item_i            start_i high and busy_o low
//  result    res_strobe_o, res_o                res_strobe_o high, one cycle
//  config    cfg_we_i, cfg_idx_i, cfg_data_i    cfg_we_i high
//
//  a load leaves busy_o low
//  a sample walks all MAX_CLASSES classes through the divider row, one class
//  a cycle, and holds busy_o while they pass the issue, read and prepare
//  stages, the 32 cells of the row, the square and saturate stages and one
//  accumulate per class
//  the result of a last sample shows on the cycle busy_o drops
//  reset clears present flags and control registers and sets the config registers; no clearing pass
//  the receiver cannot stall results
// ----------------------------------------------------------------------------
module gaussian_naive_bayes_classify_core #(
  parameter int MAX_CLASSES    = 16,
  parameter int MAX_ATTRIBUTES = 64,
  parameter int FRAC_BITS      = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  gnb_pkg::item_t   item_i,
  output logic             res_strobe_o,
  output gnb_pkg::result_t res_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [4:0]       cfg_data_i
);

  localparam int CW    = $clog2(MAX_CLASSES);
  localparam int AW    = (MAX_ATTRIBUTES > 1) ? $clog2(MAX_ATTRIBUTES) : 1;
  localparam int DEPTH = MAX_CLASSES << AW;
  localparam logic [CW-1:0] LAST_CLS = CW'(MAX_CLASSES - 1);

  // configuration registers
  logic [4:0] classes_q;
  logic [3:0] default_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      classes_q <= 5'd16;
      default_q <= 4'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gnb_pkg::CFG_CLASSES_IN_USE: classes_q <= cfg_data_i;
        gnb_pkg::CFG_DEFAULT_CLASS:  default_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // attribute wrap, worked out at elaboration
  logic [AW-1:0] wrap_tab [64];
  for (genvar g = 0; g < 64; g++) begin : g_wrap
    assign wrap_tab[g] = AW'(g % MAX_ATTRIBUTES);
  end

  logic          accept;
  logic          is_sample;
  logic          load_ok;
  logic [CW-1:0] ld_cls;
  logic [AW-1:0] in_attr;

  assign accept    = start_i && !busy_o;
  assign is_sample = (item_i.cmd == gnb_pkg::CMD_SAMPLE);
  assign load_ok   = accept && !is_sample && (32'(item_i.class_index) < MAX_CLASSES);
  assign ld_cls    = CW'(item_i.class_index);
  assign in_attr   = wrap_tab[item_i.attr_index];

  // sample context held while the classes are walked
  logic               busy_q;
  logic               open_q;
  logic               first_q;
  logic               last_q;
  logic [AW-1:0]      attr_q;
  logic signed [31:0] x_q;
  logic               iss_vld_q;
  logic [CW-1:0]      iss_q;

  // class walk: one table read a cycle
  logic               rd_vld_q;
  logic [CW-1:0]      rd_cls_q;
  logic signed [31:0] rd_mean_q, rd_dev_q;

  logic signed [31:0] mean_mem [DEPTH];
  logic signed [31:0] dev_mem  [DEPTH];
  logic signed [31:0] prior_mem [MAX_CLASSES];
  logic [MAX_CLASSES-1:0] present_q;

  always_ff @(posedge clk_i) begin
    if (load_ok && item_i.cmd == gnb_pkg::CMD_LOAD_MEAN) begin
      mean_mem[{ld_cls, in_attr}] <= item_i.value;
    end
    if (load_ok && item_i.cmd == gnb_pkg::CMD_LOAD_DEV) begin
      dev_mem[{ld_cls, in_attr}] <= item_i.value;
    end
    if (load_ok && item_i.cmd == gnb_pkg::CMD_LOAD_PRIOR) begin
      prior_mem[ld_cls] <= item_i.value;
    end
    rd_mean_q <= mean_mem[{iss_q, attr_q}];
    rd_dev_q  <= dev_mem[{iss_q, attr_q}];
    rd_cls_q  <= iss_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (load_ok && item_i.cmd == gnb_pkg::CMD_LOAD_PRIOR) begin
      present_q[ld_cls] <= item_i.present;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_sample) begin
      attr_q  <= in_attr;
      x_q     <= item_i.value;
      last_q  <= item_i.last;
      first_q <= !open_q;
    end
  end

  // term pipeline
  logic               tv;
  logic [CW-1:0]      tcls;
  logic signed [47:0] term;

  gnb_term_unit #(.TAG_W(CW), .FRAC_BITS(FRAC_BITS)) u_term (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (rd_vld_q),
    .tag_i  (rd_cls_q),
    .x_i    (x_q),
    .mean_i (rd_mean_q),
    .dev_i  (rd_dev_q),
    .vld_o  (tv),
    .tag_o  (tcls),
    .term_o (term)
  );

  // accumulate and running argmax, in class order
  logic signed [47:0] acc_q [MAX_CLASSES];
  logic signed [47:0] base;
  logic signed [48:0] sum;
  logic signed [47:0] sum_sat;
  logic signed [47:0] new_score;
  logic               cand;
  logic signed [47:0] best_q, best_d;
  logic [3:0]         idx_q, idx_d;
  logic               done;

  always_comb begin
    base      = first_q ? 48'(prior_mem[tcls]) : acc_q[tcls];
    sum       = 49'(base) + 49'(term);
    if (sum[48] != sum[47]) begin
      sum_sat = sum[48] ? gnb_pkg::ACC_MIN : gnb_pkg::ACC_MAX;
    end else begin
      sum_sat = sum[47:0];
    end
    new_score = present_q[tcls] ? sum_sat : base;
    cand      = present_q[tcls] && (32'(tcls) < 32'(classes_q)) && (new_score > best_q);
    best_d    = cand ? new_score : best_q;
    idx_d     = cand ? 4'(tcls) : idx_q;
    done      = tv && (tcls == LAST_CLS);
  end

  always_ff @(posedge clk_i) begin
    if (tv) begin
      acc_q[tcls] <= new_score;
    end
    if (accept && is_sample) begin
      best_q <= gnb_pkg::ACC_MIN;
      idx_q  <= default_q;
    end else if (tv) begin
      best_q <= best_d;
      idx_q  <= idx_d;
    end
    if (done) begin
      res_o.winner       <= idx_d;
      res_o.best_score   <= best_d;
      res_o.used_default <= (best_d == gnb_pkg::ACC_MIN);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      open_q       <= 1'b0;
      iss_vld_q    <= 1'b0;
      iss_q        <= '0;
      rd_vld_q     <= 1'b0;
      res_strobe_o <= 1'b0;
    end else begin
      rd_vld_q     <= iss_vld_q;
      res_strobe_o <= done && last_q;
      if (accept && is_sample) begin
        busy_q    <= 1'b1;
        open_q    <= !item_i.last;
        iss_vld_q <= 1'b1;
        iss_q     <= '0;
      end else begin
        if (iss_vld_q) begin
          if (iss_q == LAST_CLS) begin
            iss_vld_q <= 1'b0;
          end else begin
            iss_q <= iss_q + 1'b1;
          end
        end
        if (done) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign busy_o = busy_q;

endmodule

### rtl/core/gnb_div_cell.sv
// ----------------------------------------------------------------------------
// gnb_div_cell
// one restoring division step, registered, handing its word to the next cell
// ----------------------------------------------------------------------------
module gnb_div_cell #(
  parameter int TAG_W = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gnb_pkg::flag_t     flag_i,
  input  logic [TAG_W-1:0]   tag_i,
  input  logic [31:0]        adev_i,
  input  logic [31:0]        rem_i,
  input  logic [31:0]        low_i,
  input  logic [31:0]        q_i,
  output gnb_pkg::flag_t     flag_o,
  output logic [TAG_W-1:0]   tag_o,
  output logic [31:0]        adev_o,
  output logic [31:0]        rem_o,
  output logic [31:0]        low_o,
  output logic [31:0]        q_o
);

  logic [32:0] part;
  logic [32:0] diff;
  logic        ge;

  gnb_pkg::flag_t   flag_q;
  logic [TAG_W-1:0] tag_q;
  logic [31:0]      adev_q, rem_q, low_q, q_q;
  logic [31:0]      rem_d;

  always_comb begin
    part  = {rem_i, low_i[31]};
    diff  = part - {1'b0, adev_i};
    ge    = (part >= {1'b0, adev_i});
    rem_d = ge ? diff[31:0] : part[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= '0;
    end else begin
      flag_q <= flag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= tag_i;
    adev_q <= adev_i;
    rem_q  <= rem_d;
    low_q  <= {low_i[30:0], 1'b0};
    q_q    <= {q_i[30:0], ge};
  end

  assign flag_o = flag_q;
  assign tag_o  = tag_q;
  assign adev_o = adev_q;
  assign rem_o  = rem_q;
  assign low_o  = low_q;
  assign q_o    = q_q;

endmodule

### rtl/core/gnb_term_unit.sv
// ----------------------------------------------------------------------------
// gnb_term_unit
// pipelined gaussian term: difference, row of divider cells, square, saturate
// ----------------------------------------------------------------------------
module gnb_term_unit #(
  parameter int TAG_W     = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  logic [TAG_W-1:0]   tag_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] mean_i,
  input  logic signed [31:0] dev_i,
  output logic               vld_o,
  output logic [TAG_W-1:0]   tag_o,
  output logic signed [47:0] term_o
);

  localparam int NUM_CELLS = 32;
  localparam int DW        = 33 + FRAC_BITS;

  logic signed [32:0] diff;
  logic [32:0]        ad;
  logic [31:0]        adev;
  logic [DW-1:0]      dividend;
  logic [FRAC_BITS:0] hi;
  logic               ovf;

  gnb_pkg::flag_t   flag_c [NUM_CELLS+1];
  logic [TAG_W-1:0] tag_c  [NUM_CELLS+1];
  logic [31:0]      adev_c [NUM_CELLS+1];
  logic [31:0]      rem_c  [NUM_CELLS+1];
  logic [31:0]      low_c  [NUM_CELLS+1];
  logic [31:0]      q_c    [NUM_CELLS+1];

  gnb_pkg::flag_t   flag_p_q;
  logic [TAG_W-1:0] tag_p_q;
  logic [31:0]      adev_p_q, rem_p_q, low_p_q;

  always_comb begin
    diff     = 33'(x_i) - 33'(mean_i);
    ad       = diff[32] ? 33'(-diff) : 33'(diff);
    adev     = dev_i[31] ? 32'(-dev_i) : 32'(dev_i);
    dividend = {ad, {FRAC_BITS{1'b0}}};
    hi       = dividend[DW-1:32];
    // quotient would need more than 32 bits
    ovf      = ({{(32-FRAC_BITS){1'b0}}, hi} >= {1'b0, adev});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_p_q <= '0;
    end else begin
      flag_p_q.vld <= vld_i;
      flag_p_q.sat <= ovf || (adev == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    tag_p_q  <= tag_i;
    adev_p_q <= adev;
    rem_p_q  <= {{(31-FRAC_BITS){1'b0}}, hi};
    low_p_q  <= dividend[31:0];
  end

  assign flag_c[0] = flag_p_q;
  assign tag_c[0]  = tag_p_q;
  assign adev_c[0] = adev_p_q;
  assign rem_c[0]  = rem_p_q;
  assign low_c[0]  = low_p_q;
  assign q_c[0]    = '0;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    gnb_div_cell #(.TAG_W(TAG_W)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .flag_i (flag_c[g]),
      .tag_i  (tag_c[g]),
      .adev_i (adev_c[g]),
      .rem_i  (rem_c[g]),
      .low_i  (low_c[g]),
      .q_i    (q_c[g]),
      .flag_o (flag_c[g+1]),
      .tag_o  (tag_c[g+1]),
      .adev_o (adev_c[g+1]),
      .rem_o  (rem_c[g+1]),
      .low_o  (low_c[g+1]),
      .q_o    (q_c[g+1])
    );
  end

  gnb_pkg::flag_t   flag_m_q;
  logic [TAG_W-1:0] tag_m_q;
  logic [63:0]      sq_q;
  logic [63:0]      mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_m_q <= '0;
      vld_o    <= 1'b0;
    end else begin
      flag_m_q <= flag_c[NUM_CELLS];
      vld_o    <= flag_m_q.vld;
    end
  end

  always_comb begin
    mag = sq_q >> (FRAC_BITS + 1);
  end

  always_ff @(posedge clk_i) begin
    tag_m_q <= tag_c[NUM_CELLS];
    sq_q    <= q_c[NUM_CELLS] * q_c[NUM_CELLS];
    tag_o   <= tag_m_q;
    if (flag_m_q.sat || (mag[63:47] != '0)) begin
      term_o <= gnb_pkg::ACC_MIN;
    end else begin
      term_o <= -$signed({1'b0, mag[46:0]});
    end
  end

endmodule

### rtl/core/gnb_checker.sv
// ----------------------------------------------------------------------------
// gnb_checker
// port-level checks of the classifier core, bound to the top level
// ----------------------------------------------------------------------------
module gnb_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input gnb_pkg::item_t   item_i,
  input logic             res_strobe_o,
  input gnb_pkg::result_t res_o
);

  // a sample transfer starts processing
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && item_i.cmd == gnb_pkg::CMD_SAMPLE |=> busy_o)
    else $error("sample did not raise busy");

  // a load transfer never starts processing
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && item_i.cmd != gnb_pkg::CMD_SAMPLE |=> !busy_o)
    else $error("load raised busy");

  // a result closes a period of processing
  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(busy_o) && !busy_o)
    else $error("result without processing");

  // default flag agrees with the score
  a_default_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> (res_o.used_default == (res_o.best_score == gnb_pkg::ACC_MIN)))
    else $error("default flag disagrees with score");

  // result strobes never come back to back
  a_single_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |=> !res_strobe_o)
    else $error("back to back results");

endmodule

bind gaussian_naive_bayes_classify_core gnb_checker u_gnb_checker (.*);
